// File: design/bdt_pkg.sv
// ----------------------------------------------------------------------------
// bdt_pkg
// Shared types and constants for the baseline deviation trigger unit.
// ----------------------------------------------------------------------------
package bdt_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int TIME_W    = 32;
  localparam int SUM_W     = 24;
  localparam int RESTART_W = 4;
  localparam int CFG_W     = 16;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 72;

  localparam logic [SAMPLE_W-1:0]  JUMP_LIMIT   = 16'd1000;
  localparam logic [RESTART_W-1:0] MAX_RESTARTS = 4'd10;

  localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd1000;
  localparam logic [CFG_W-1:0] HOLD_OFF_RESET  = 16'd1000;

  typedef enum logic [0:0] {
    REG_TRIGGER_THRESHOLD = 1'b0,
    REG_HOLD_OFF_MS       = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] last_trigger_deviation;
    logic [SAMPLE_W-1:0] last_deviation;
    logic [SAMPLE_W-1:0] last_reading;
    logic [SAMPLE_W-1:0] baseline;
    logic                calibrating;
    logic                detected;
  } result_t;

endpackage

// File: design/baseline_deviation_trigger_unit.sv
// ----------------------------------------------------------------------------
// baseline_deviation_trigger_unit
// Calibrates a baseline from color-temperature samples and flags samples
// whose deviation from it exceeds a threshold outside a hold-off window.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// in_*      slave      one sample request: color_temp, now_ms, recalibrate
// out_*     master     one result per sample request
// cfg_*     write      trigger_threshold (index 0), hold_off_ms (index 1)
//
// Every request is worked combinationally from the input port into the result
// register, so one request per clock is taken when the result side keeps up.
// The path is set by the calibration add and the reciprocal multiply that
// forms the baseline. rst_n is synchronous and restarts calibration.
// in_tready is high while the result register is empty or being taken.
// ----------------------------------------------------------------------------
module baseline_deviation_trigger_unit
  import bdt_pkg::*;
#(
  parameter int CAL_SAMPLES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // color_temp[15:0], now_ms[47:16], recalibrate[48], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // detected[0], calibrating[1], baseline[17:2], last_reading[33:18],
  // last_deviation[49:34], last_trigger_deviation[65:50], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int LEFT_W   = $clog2(CAL_SAMPLES + 1);
  localparam int LOG_N    = $clog2(CAL_SAMPLES);
  localparam int SHIFT    = SUM_W + LOG_N;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + longint'(CAL_SAMPLES) - 64'd1) / longint'(CAL_SAMPLES);
  localparam int RECIP_W  = SUM_W + 2;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_C  = RECIP_W'(RECIP);
  localparam logic [LEFT_W-1:0]  LEFT_RST = LEFT_W'(CAL_SAMPLES);

  logic [CFG_W-1:0]     threshold_r;
  logic [CFG_W-1:0]     hold_off_r;

  logic                 in_cal_r, in_cal_nxt;
  logic [LEFT_W-1:0]    left_r, left_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [SAMPLE_W-1:0]  prev_r, prev_nxt;
  logic                 have_prev_r, have_prev_nxt;
  logic [RESTART_W-1:0] restart_r, restart_nxt;
  logic [SAMPLE_W-1:0]  avg_r, avg_nxt;
  logic [SAMPLE_W-1:0]  reading_r, reading_nxt;
  logic [SAMPLE_W-1:0]  dev_r, dev_nxt;
  logic [SAMPLE_W-1:0]  trig_dev_r, trig_dev_nxt;
  logic [TIME_W-1:0]    trig_time_r, trig_time_nxt;

  logic                 out_valid_r;
  result_t              result_r, result_nxt;

  logic [SAMPLE_W-1:0]  sample;
  logic [TIME_W-1:0]    now;
  logic                 recal;
  logic                 accept;

  logic                 cal_active;
  logic                 have_prev_eff;
  logic [SAMPLE_W-1:0]  prev_eff;
  logic [RESTART_W-1:0] restart_eff;
  logic [SUM_W-1:0]     sum_eff;
  logic [LEFT_W-1:0]    left_eff;
  logic [SAMPLE_W-1:0]  avg_eff;
  logic [SAMPLE_W-1:0]  jump;
  logic                 restart;
  logic [SUM_W-1:0]     sum_add;
  logic [PROD_W-1:0]    prod;
  logic [PROD_W-1:0]    prod_sh;
  logic [SAMPLE_W-1:0]  quot;
  logic [TIME_W-1:0]    elapsed;
  logic [TIME_W-1:0]    hold_ext;
  logic [SAMPLE_W-1:0]  dev;

  assign sample = in_tdata[15:0];
  assign now    = in_tdata[47:16];
  assign recal  = in_tdata[48];

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, result_r};

  always_comb begin
    cal_active    = recal || in_cal_r;
    have_prev_eff = recal ? 1'b0 : have_prev_r;
    prev_eff      = have_prev_eff ? prev_r : sample;
    restart_eff   = recal ? '0 : restart_r;
    sum_eff       = recal ? '0 : sum_r;
    left_eff      = recal ? LEFT_RST : left_r;
    avg_eff       = recal ? '0 : avg_r;

    jump    = (sample > prev_eff) ? (sample - prev_eff) : (prev_eff - sample);
    restart = (jump > JUMP_LIMIT) && (restart_eff < MAX_RESTARTS);
    sum_add = sum_eff + SUM_W'(sample);
    prod    = PROD_W'(sum_add) * PROD_W'(RECIP_C);
    prod_sh = prod >> SHIFT;
    quot    = prod_sh[SAMPLE_W-1:0];

    elapsed  = now - trig_time_r;
    hold_ext = TIME_W'(hold_off_r);
    dev      = (avg_r > sample) ? (avg_r - sample) : (sample - avg_r);

    in_cal_nxt    = in_cal_r;
    left_nxt      = left_r;
    sum_nxt       = sum_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    restart_nxt   = restart_r;
    avg_nxt       = avg_r;
    reading_nxt   = reading_r;
    dev_nxt       = dev_r;
    trig_dev_nxt  = trig_dev_r;
    trig_time_nxt = trig_time_r;
    result_nxt.detected    = 1'b0;
    result_nxt.calibrating = 1'b0;

    if (cal_active) begin
      result_nxt.calibrating = 1'b1;
      in_cal_nxt    = 1'b1;
      have_prev_nxt = 1'b1;
      prev_nxt      = sample;
      avg_nxt       = avg_eff;
      if (restart) begin
        left_nxt    = LEFT_RST;
        sum_nxt     = '0;
        restart_nxt = restart_eff + RESTART_W'(1);
      end else begin
        sum_nxt     = sum_add;
        restart_nxt = restart_eff;
        left_nxt    = left_eff - LEFT_W'(1);
        if (left_eff == LEFT_W'(1)) begin
          avg_nxt    = quot;
          in_cal_nxt = 1'b0;
        end
      end
    end else if (elapsed >= hold_ext) begin
      reading_nxt = sample;
      dev_nxt     = dev;
      if (dev > threshold_r) begin
        trig_dev_nxt          = dev;
        result_nxt.detected   = 1'b1;
        if (elapsed > hold_ext) begin
          trig_time_nxt = now;
        end
      end
    end

    result_nxt.baseline               = avg_nxt;
    result_nxt.last_reading           = reading_nxt;
    result_nxt.last_deviation         = dev_nxt;
    result_nxt.last_trigger_deviation = trig_dev_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
      hold_off_r  <= HOLD_OFF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_TRIGGER_THRESHOLD: threshold_r <= cfg_wdata;
        REG_HOLD_OFF_MS:       hold_off_r  <= cfg_wdata;
        default:               threshold_r <= threshold_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cal_r    <= 1'b1;
      left_r      <= LEFT_RST;
      sum_r       <= '0;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      restart_r   <= '0;
      avg_r       <= '0;
      reading_r   <= '0;
      dev_r       <= '0;
      trig_dev_r  <= '0;
      trig_time_r <= '0;
    end else if (accept) begin
      in_cal_r    <= in_cal_nxt;
      left_r      <= left_nxt;
      sum_r       <= sum_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      restart_r   <= restart_nxt;
      avg_r       <= avg_nxt;
      reading_r   <= reading_nxt;
      dev_r       <= dev_nxt;
      trig_dev_r  <= trig_dev_nxt;
      trig_time_r <= trig_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_r <= result_nxt;
    end
  end

endmodule

// File: bench/bdt_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bdt_result_checker
// Watches the request, result and register ports of the trigger unit. It keeps
// its own copy of the calibration, baseline and hold-off state, works out the
// result of every accepted request, and compares each result field by field.
// ----------------------------------------------------------------------------
module bdt_result_checker
  import bdt_pkg::*;
#(
  parameter int CAL_SAMPLES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  // color_temp[15:0], now_ms[47:16], recalibrate[48], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // detected[0], calibrating[1], baseline[17:2], last_reading[33:18],
  // last_deviation[49:34], last_trigger_deviation[65:50], zero pad
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  cfg_reg_t              cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  output int                    mismatch_count,
  output int                    results_pending
);

  logic [CFG_W-1:0]     threshold;
  logic [CFG_W-1:0]     hold_off;
  logic                 in_cal;
  logic [8:0]           samples_left;
  logic [SUM_W-1:0]     cal_sum;
  logic [SAMPLE_W-1:0]  prev_sample;
  logic                 have_prev;
  logic [RESTART_W-1:0] restart_cnt;
  logic [SAMPLE_W-1:0]  baseline_avg;
  logic [SAMPLE_W-1:0]  reading_held;
  logic [SAMPLE_W-1:0]  deviation_held;
  logic [SAMPLE_W-1:0]  trigger_dev_held;
  logic [TIME_W-1:0]    last_trigger;
  result_t              results_due[$];
  result_t              seen;
  result_t              due;

  initial begin
    mismatch_count  = 0;
    results_pending = 0;
  end

  function automatic logic [SAMPLE_W-1:0] distance(logic [SAMPLE_W-1:0] a,
                                                   logic [SAMPLE_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic report_failure(input string msg);
    $display("%0t ns: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [SAMPLE_W-1:0] got,
                             input logic [SAMPLE_W-1:0] want);
    if (got !== want) begin
      report_failure($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
    end
  endtask

  task automatic step_trigger_model(input logic [SAMPLE_W-1:0] temp,
                                    input logic [TIME_W-1:0] stamp, input logic recal);
    result_t             res;
    logic [TIME_W-1:0]   elapsed;
    logic [SAMPLE_W-1:0] dev;
    res = '0;
    if (recal) begin
      in_cal       = 1'b1;
      samples_left = 9'(CAL_SAMPLES);
      cal_sum      = '0;
      have_prev    = 1'b0;
      restart_cnt  = '0;
      baseline_avg = '0;
    end
    if (in_cal) begin
      res.calibrating = 1'b1;
      if (!have_prev) begin
        prev_sample = temp;
        have_prev   = 1'b1;
      end
      if (distance(temp, prev_sample) > JUMP_LIMIT && restart_cnt < MAX_RESTARTS) begin
        samples_left = 9'(CAL_SAMPLES);
        cal_sum      = '0;
        restart_cnt  = restart_cnt + 1'b1;
        prev_sample  = temp;
      end else begin
        cal_sum     = cal_sum + SUM_W'(temp);
        prev_sample = temp;
        if (samples_left != 0) samples_left = samples_left - 1'b1;
        if (samples_left == 0) begin
          baseline_avg = SAMPLE_W'(cal_sum / CAL_SAMPLES);
          in_cal       = 1'b0;
        end
      end
    end else begin
      elapsed = stamp - last_trigger;
      if (elapsed >= TIME_W'(hold_off)) begin
        dev            = distance(baseline_avg, temp);
        reading_held   = temp;
        deviation_held = dev;
        if (dev > threshold) begin
          trigger_dev_held = dev;
          if (elapsed > TIME_W'(hold_off)) last_trigger = stamp;
          res.detected = 1'b1;
        end
      end
    end
    res.baseline               = baseline_avg;
    res.last_reading           = reading_held;
    res.last_deviation         = deviation_held;
    res.last_trigger_deviation = trigger_dev_held;
    results_due.push_back(res);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      threshold        = THRESHOLD_RESET;
      hold_off         = HOLD_OFF_RESET;
      in_cal           = 1'b1;
      samples_left     = 9'(CAL_SAMPLES);
      cal_sum          = '0;
      prev_sample      = '0;
      have_prev        = 1'b0;
      restart_cnt      = '0;
      baseline_avg     = '0;
      reading_held     = '0;
      deviation_held   = '0;
      trigger_dev_held = '0;
      last_trigger     = '0;
      results_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_TRIGGER_THRESHOLD: threshold = cfg_wdata;
          REG_HOLD_OFF_MS:       hold_off  = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        seen = result_t'(out_tdata[$bits(result_t)-1:0]);
        if (results_due.size() == 0) begin
          report_failure("result arrived with no request pending");
        end else begin
          due = results_due.pop_front();
          check_field("detected", SAMPLE_W'(seen.detected), SAMPLE_W'(due.detected));
          check_field("calibrating", SAMPLE_W'(seen.calibrating),
                      SAMPLE_W'(due.calibrating));
          check_field("baseline", seen.baseline, due.baseline);
          check_field("last_reading", seen.last_reading, due.last_reading);
          check_field("last_deviation", seen.last_deviation, due.last_deviation);
          check_field("last_trigger_deviation", seen.last_trigger_deviation,
                      due.last_trigger_deviation);
        end
      end
      if (in_tvalid && in_tready) begin
        step_trigger_model(in_tdata[15:0], in_tdata[47:16], in_tdata[48]);
      end
    end
    results_pending = results_due.size();
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives sample requests and register writes into the trigger unit with
// random gaps and stalls on both channels, and reports the final verdict.
// A directed opening covers calibration, restarts and the hold-off edges.
// ----------------------------------------------------------------------------
module tb;
  import bdt_pkg::*;

  localparam int CAL_SAMPLES = 16;
  localparam int CYCLE_LIMIT = 200000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  cfg_reg_t              cfg_addr   = REG_TRIGGER_THRESHOLD;
  logic [CFG_W-1:0]      cfg_wdata  = '0;

  int          mismatch_count;
  int          results_pending;
  int          send_idle_pct     = 0;
  int          recv_idle_pct     = 0;
  bit          hold_back_request = 1'b0;
  bit          hold_done         = 1'b0;
  int          hold_left         = 0;
  int          requests_sent     = 0;
  int          cycle_count       = 0;
  logic [31:0] clock_ms          = '0;

  always #1 clk = ~clk;

  baseline_deviation_trigger_unit #(
    .CAL_SAMPLES(CAL_SAMPLES)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  bdt_result_checker #(
    .CAL_SAMPLES(CAL_SAMPLES)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending)
  );

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_back_request && !hold_done) begin
      hold_left  <= 80;
      hold_done  <= 1'b1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [31:0] tick(input int step_max);
    if ($urandom_range(0, 49) == 0) begin
      clock_ms += $urandom;
    end else begin
      clock_ms += $urandom_range(0, step_max);
    end
    return clock_ms;
  endfunction

  function automatic logic [15:0] near(input int level, input int span);
    int v;
    v = $urandom_range(0, 1) ? level + span : level - span;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  task automatic send_sample(input logic [15:0] temp, input logic [31:0] stamp,
                             input logic recal);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {7'b0, recal, stamp, temp};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_trigger_settings(input logic [15:0] threshold,
                                       input logic [15:0] hold_off);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_TRIGGER_THRESHOLD;
    cfg_wdata <= threshold;
    @(posedge clk);
    cfg_addr  <= REG_HOLD_OFF_MS;
    cfg_wdata <= hold_off;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_random_items(input int count, input int step_max);
    int target;
    int level;
    int span;
    int lo;
    int hi;
    target = requests_sent + count;
    while (requests_sent < target) begin
      level = $urandom_range(0, 65535);
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 6)) begin
            clock_ms = $urandom;
            send_sample(16'($urandom), clock_ms, $urandom_range(0, 9) == 0);
          end
        end
        1, 2: begin
          lo = $urandom_range(0, 30000);
          hi = lo + $urandom_range(1001, 35535);
          send_sample(16'(lo), tick(step_max), 1'b1);
          for (int k = 0; k < 14; k++) begin
            send_sample(16'((k % 2 == 0) ? hi : lo), tick(step_max), 1'b0);
          end
        end
        default: begin
          send_sample(16'(level), tick(step_max), 1'b1);
          repeat (CAL_SAMPLES - 1 + $urandom_range(0, 2)) begin
            span = ($urandom_range(0, 19) == 0) ? $urandom_range(1001, 6000)
                                                : $urandom_range(0, 400);
            send_sample(near(level, span), tick(step_max), 1'b0);
          end
          repeat ($urandom_range(4, 30)) begin
            send_sample(near(level, $urandom_range(0, 3000)), tick(step_max), 1'b0);
          end
        end
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 28;
    recv_idle_pct = 83;
    send_sample(16'd0, 32'd0, 1'b0);
    send_sample(16'hFFFF, 32'd1, 1'b0);
    repeat (CAL_SAMPLES) send_sample(16'hFFFF, 32'd2, 1'b0);
    send_sample(16'hFFFF, 32'd999, 1'b0);
    send_sample(16'd0, 32'd1000, 1'b0);
    send_sample(16'd64535, 32'd1000, 1'b0);
    send_sample(16'd64534, 32'd1001, 1'b0);
    send_sample(16'd0, 32'd1500, 1'b0);
    send_sample(16'd0, 32'hFFFF_FFFF, 1'b0);
    send_sample(16'hFFFF, 32'd0, 1'b0);
    send_sample(16'd12345, 32'd5000, 1'b1);
    drain_results();

    load_trigger_settings(16'($urandom_range(200, 1500)), 16'($urandom_range(0, 8)));
    run_random_items(175, 20);
    drain_results();

    send_idle_pct = 83;
    recv_idle_pct = 28;
    load_trigger_settings(16'h0000, 16'h0000);
    run_random_items(175, 3);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_trigger_settings(16'hFFFF, 16'hFFFF);
    hold_back_request = 1'b1;
    run_random_items(175, 70000);
    drain_results();

    load_trigger_settings(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 300)));
    run_random_items(175, 400);
    drain_results();
    repeat (10) @(posedge clk);

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
